// ===== src/cts_pkg.sv =====
// Shared types, constants and float helpers for the correlation-to-Stokes extractor.
// No dependencies.
package cts_pkg;

	localparam int QUEUE_DEPTH = 4;

	typedef enum logic [2:0] {
		MODE_INSTR  = 3'd0,
		MODE_DIAG   = 3'd1,
		MODE_SINGLE = 3'd2,
		MODE_I      = 3'd3,
		MODE_Q      = 3'd4,
		MODE_U      = 3'd5,
		MODE_V      = 3'd6,
		MODE_BAD    = 3'd7
	} mode_t;

	localparam logic [2:0] REG_MODE   = 3'd0;
	localparam logic [2:0] REG_COUNT  = 3'd1;
	localparam logic [2:0] REG_FIRST  = 3'd2;
	localparam logic [2:0] REG_SECOND = 3'd3;
	localparam logic [2:0] REG_BASIS  = 3'd4;

	typedef struct packed {
		logic [31:0] corr0_re;
		logic [31:0] corr0_im;
		logic [31:0] corr1_re;
		logic [31:0] corr1_im;
		logic [31:0] corr2_re;
		logic [31:0] corr2_im;
		logic [31:0] corr3_re;
		logic [31:0] corr3_im;
		logic        range_end;
	} in_item_t;

	typedef struct packed {
		logic [31:0] value_re;
		logic [31:0] value_im;
		logic        run_last;
		logic        channel_range_end;
		logic        mode_error;
	} out_item_t;

	typedef enum logic [1:0] {
		KIND_COPY  = 2'd0,
		KIND_STOKES = 2'd1,
		KIND_ERROR = 2'd2
	} kind_t;

	// One queued command: up to four operand pairs, a count of results and how
	// to produce them.
	typedef struct packed {
		kind_t       kind;
		logic [1:0]  last_idx;
		logic [3:0][63:0] pair;
		logic        use_sum;
		logic        rot;
		logic        range_end;
	} cmd_t;

	typedef struct packed {
		logic [31:0] value_re;
		logic [31:0] value_im;
		logic        run_last;
		logic        range_end;
		logic        err;
	} res_t;

	// Multiply by one half, round to nearest even.
	function automatic logic [31:0] fp_half(input logic [31:0] x);
		logic [7:0]  e;
		logic [22:0] m;
		logic [24:0] sig;
		logic [23:0] q;
		begin
			e = x[30:23];
			m = x[22:0];
			if (e == 8'hFF) begin
				fp_half = x;
			end else if (e > 8'd1) begin
				fp_half = {x[31], e - 8'd1, m};
			end else begin
				sig = {1'b0, (e == 8'd1), m};
				q = sig[24:1];
				if (sig[0] && q[0])
					q = q + 24'd1;
				fp_half = {x[31], 8'd0, 23'd0} | {8'd0, q};
			end
		end
	endfunction

endpackage

// ===== src/correlation_to_stokes_extract.sv =====
// Top level of the correlation-to-Stokes extractor: front end, command queue, back end.
// Depends on cts_pkg, cts_front and cts_back.
// Throughput: one result per cycle; an item yields one to four results on the result
// port (four in instrumental mode), and busy rises at QUEUE_DEPTH-1 queued commands.
// Reset clears the queue and the sequencer and restores the register reset values.
module correlation_to_stokes_extract #(
	parameter int QUEUE_DEPTH = cts_pkg::QUEUE_DEPTH
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  cts_pkg::in_item_t   item_in,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [2:0]          cfg_index,
	input  logic [31:0]         cfg_data,
	output logic                result_strobe,
	output cts_pkg::out_item_t  result
);
	import cts_pkg::*;

	cmd_t cmd;
	res_t res;
	logic full;

	assign cfg_ready = 1'b1;
	assign busy = full;

	cts_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.item      (item_in),
		.cmd       (cmd)
	);

	cts_back #(.DEPTH(QUEUE_DEPTH)) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (start && !full),
		.cmd    (cmd),
		.full   (full),
		.strobe (result_strobe),
		.res    (res)
	);

	assign result.value_re = res.value_re;
	assign result.value_im = res.value_im;
	assign result.run_last = res.run_last;
	assign result.channel_range_end = res.range_end;
	assign result.mode_error = res.err;
endmodule

// ===== src/cts_fadd.sv =====
// Single-precision adder, two stages, round to nearest even.
// Depends on cts_pkg.
module cts_fadd (
	input  logic        clk,
	input  logic [31:0] a,
	input  logic [31:0] b,
	output logic [31:0] y
);
	import cts_pkg::*;

	logic        big_s, sml_s;
	logic [7:0]  big_e, sml_e;
	logic [26:0] big_m, sml_m, sml_sh;
	logic [7:0]  d;
	logic        sticky;
	logic        sub;
	logic        spec;
	logic [31:0] spec_v;
	logic [27:0] sum_s1;
	logic        sign_s1, spec_s1, zero_s1;
	logic [7:0]  exp_s1;
	logic [31:0] spec_v_s1;
	logic [4:0]  lz;
	logic [27:0] norm;
	logic [9:0]  e_n;
	logic [26:0] fm;
	logic [24:0] rnd;
	logic [9:0]  e_r;
	logic        g;

	always_comb begin
		logic a_big;
		a_big = a[30:0] >= b[30:0];
		big_s = a_big ? a[31] : b[31];
		sml_s = a_big ? b[31] : a[31];
		big_e = a_big ? a[30:23] : b[30:23];
		sml_e = a_big ? b[30:23] : a[30:23];
		big_m = {(big_e != 8'd0), (a_big ? a[22:0] : b[22:0]), 3'b000};
		sml_m = {(sml_e != 8'd0), (a_big ? b[22:0] : a[22:0]), 3'b000};
		d = (big_e == 8'd0 ? 8'd1 : big_e) - (sml_e == 8'd0 ? 8'd1 : sml_e);
		if (d > 8'd26) begin
			sml_sh = 27'd0;
			sticky = |sml_m;
		end else begin
			sml_sh = sml_m >> d;
			sticky = |(sml_m & ((27'd1 << d) - 27'd1));
		end
		sml_sh[0] = sml_sh[0] | sticky;
		sub = big_s ^ sml_s;
		spec = (a[30:23] == 8'hFF) || (b[30:23] == 8'hFF);
		spec_v = 32'h7F800000;
	end

	always_ff @(posedge clk) begin
		sum_s1 <= sub ? {1'b0, big_m} - {1'b0, sml_sh} : {1'b0, big_m} + {1'b0, sml_sh};
		sign_s1 <= big_s;
		exp_s1 <= big_e == 8'd0 ? 8'd1 : big_e;
		spec_s1 <= spec;
		spec_v_s1 <= spec_v;
		zero_s1 <= sub && (a[30:0] == b[30:0]);
	end

	always_comb begin
		lz = 5'd0;
		for (int i = 27; i >= 0; i--) begin
			if (sum_s1[i] && lz == 5'd0 && !(|(sum_s1 >> (i + 1))))
				lz = 5'(27 - i);
		end
		if (sum_s1[27]) begin
			norm = {1'b0, sum_s1[27:2], sum_s1[1] | sum_s1[0]};
			e_n = {2'b0, exp_s1} + 10'd1;
		end else if ({2'b0, exp_s1} > {5'd0, lz} - 10'd0 + 10'd0 && lz > 5'd0 &&
			{2'b0, exp_s1} > 10'(lz - 5'd1)) begin
			norm = sum_s1 << (lz - 5'd1);
			e_n = {2'b0, exp_s1} - 10'(lz - 5'd1);
		end else if (lz > 5'd0) begin
			norm = sum_s1 << (exp_s1 - 8'd1);
			e_n = 10'd1;
		end else begin
			norm = sum_s1;
			e_n = {2'b0, exp_s1};
		end
		fm = norm[26:0];
		g = fm[2] & (fm[1] | fm[0] | fm[3]);
		rnd = {1'b0, fm[26:3]} + {24'd0, g};
		e_r = e_n;
		if (rnd[24]) begin
			rnd = rnd >> 1;
			e_r = e_n + 10'd1;
		end
		if (e_r == 10'd1 && !rnd[23])
			e_r = 10'd0;
		if (spec_s1)
			y = spec_v_s1;
		else if (zero_s1 || sum_s1 == 28'd0)
			y = {sign_s1 && !zero_s1, 31'd0};
		else if (e_r >= 10'd255)
			y = {sign_s1, 8'hFF, 23'd0};
		else
			y = {sign_s1, e_r[7:0], rnd[22:0]};
	end
endmodule

// ===== src/cts_front.sv =====
// Front end: holds the registers, classifies each item into a command.
// Depends on cts_pkg.
module cts_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	input  cts_pkg::in_item_t  item,
	output cts_pkg::cmd_t      cmd
);
	import cts_pkg::*;

	logic [2:0] mode_q, count_q;
	logic [1:0] first_q, second_q;
	logic       basis_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 3'd3;
			count_q <= 3'd4;
			first_q <= 2'd0;
			second_q <= 2'd3;
			basis_q <= 1'b0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_MODE:   mode_q <= cfg_data[2:0];
				REG_COUNT:  count_q <= cfg_data[2:0];
				REG_FIRST:  first_q <= cfg_data[1:0];
				REG_SECOND: second_q <= cfg_data[1:0];
				REG_BASIS:  basis_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		logic [3:0][63:0] s;
		logic cnt_ok, fa, fb;
		s[0] = {item.corr0_re, item.corr0_im};
		s[1] = {item.corr1_re, item.corr1_im};
		s[2] = {item.corr2_re, item.corr2_im};
		s[3] = {item.corr3_re, item.corr3_im};
		cnt_ok = count_q != 3'd0 && count_q <= 3'd4;
		fa = {1'b0, first_q} < count_q;
		fb = {1'b0, second_q} < count_q;
		cmd = '0;
		cmd.kind = KIND_ERROR;
		cmd.range_end = item.range_end;
		cmd.pair = s;
		if (cnt_ok) begin
			unique case (mode_t'(mode_q))
				MODE_INSTR: if (count_q == 3'd4) begin
					cmd.kind = KIND_COPY;
					cmd.last_idx = 2'd3;
				end
				MODE_DIAG: if (count_q == 3'd4 || count_q == 3'd2) begin
					cmd.kind = KIND_COPY;
					cmd.last_idx = 2'd1;
					cmd.pair[1] = count_q == 3'd4 ? s[3] : s[1];
				end
				MODE_SINGLE: if (fa) begin
					cmd.kind = KIND_COPY;
					cmd.pair[0] = s[first_q];
				end
				MODE_I, MODE_Q, MODE_U, MODE_V: if (fa && fb) begin
					cmd.kind = KIND_STOKES;
					cmd.pair[0] = s[first_q];
					cmd.pair[1] = s[second_q];
					cmd.use_sum = mode_q == MODE_I || (mode_q == MODE_Q && basis_q) ||
						(mode_q == MODE_U && !basis_q);
					cmd.rot = (mode_q == MODE_U && basis_q) || (mode_q == MODE_V && !basis_q);
				end
				default: ;
			endcase
		end
	end
endmodule

// ===== src/cts_back.sv =====
// Back end: queue of commands, result sequencer and the two-stage Stokes adders.
// Depends on cts_pkg and cts_fadd.
module cts_back #(
	parameter int DEPTH = cts_pkg::QUEUE_DEPTH
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  cts_pkg::cmd_t cmd,
	output logic          full,
	output logic          strobe,
	output cts_pkg::res_t res
);
	import cts_pkg::*;

	localparam int AW = $clog2(DEPTH);

	cmd_t            mem_q [DEPTH];
	logic [AW-1:0]   wp_q, rp_q;
	logic [AW:0]     cnt_q;
	logic [1:0]      idx_q;
	logic            pop;
	cmd_t            head;
	res_t            r_s1, r_s2;
	logic            v_s1, v_s2, st_s1, st_s2, rot_s1, rot_s2;
	logic [31:0]     fr, fi, hr, hi;

	assign head = mem_q[rp_q];
	assign full = cnt_q >= (AW+1)'(DEPTH - 1);
	assign pop = cnt_q != '0 && (head.kind != KIND_COPY || idx_q == head.last_idx);

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wp_q] <= cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
			idx_q <= '0;
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (push)
				wp_q <= wp_q == AW'(DEPTH - 1) ? '0 : wp_q + 1'b1;
			if (pop)
				rp_q <= rp_q == AW'(DEPTH - 1) ? '0 : rp_q + 1'b1;
			cnt_q <= cnt_q + (AW+1)'(push) - (AW+1)'(pop);
			if (pop)
				idx_q <= '0;
			else if (cnt_q != '0)
				idx_q <= idx_q + 2'd1;
			v_s1 <= cnt_q != '0;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		r_s1.value_re <= head.pair[idx_q][63:32];
		r_s1.value_im <= head.pair[idx_q][31:0];
		r_s1.run_last <= head.kind != KIND_COPY || idx_q == head.last_idx;
		r_s1.range_end <= head.range_end;
		r_s1.err <= head.kind == KIND_ERROR;
		st_s1 <= head.kind == KIND_STOKES;
		rot_s1 <= head.rot;
		r_s2 <= r_s1;
		st_s2 <= st_s1;
		rot_s2 <= rot_s1;
	end

	cts_fadd u_add_re (
		.clk (clk),
		.a   (head.pair[0][63:32]),
		.b   (head.pair[1][63:32] ^ {~head.use_sum, 31'd0}),
		.y   (fr)
	);
	cts_fadd u_add_im (
		.clk (clk),
		.a   (head.pair[0][31:0]),
		.b   (head.pair[1][31:0] ^ {~head.use_sum, 31'd0}),
		.y   (fi)
	);

	// The adders hold one register inside; their result, registered once more, lines up with stage two.
	logic [31:0] fr_s2, fi_s2;
	always_ff @(posedge clk) begin
		fr_s2 <= fr;
		fi_s2 <= fi;
	end

	always_comb begin
		logic [31:0] vr, vi;
		res = r_s2;
		vr = r_s2.value_re;
		vi = r_s2.value_im;
		if (st_s2) begin
			hr = fp_half(fr_s2);
			hi = fp_half(fi_s2);
			vr = rot_s2 ? hi : hr;
			vi = rot_s2 ? (hr ^ 32'h80000000) : hi;
		end else begin
			hr = '0;
			hi = '0;
		end
		if (vr[30:23] == 8'hFF || vi[30:23] == 8'hFF || r_s2.err) begin
			vr = '0;
			vi = '0;
		end
		res.value_re = vr;
		res.value_im = vi;
	end
	assign strobe = v_s2;
endmodule

// ===== src/cts_checker.sv =====
// Port-level checks for the correlation-to-Stokes extractor, bound to the top level.
// Depends on cts_pkg.
module cts_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               result_strobe,
	input cts_pkg::out_item_t result
);
	import cts_pkg::*;

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe && result.mode_error |-> result.value_re == 32'd0 &&
		result.value_im == 32'd0 && result.run_last) else $error("error result not zero");
	a_finite_re: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe |-> result.value_re[30:23] != 8'hFF) else $error("non-finite re");
	a_finite_im: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe |-> result.value_im[30:23] != 8'hFF) else $error("non-finite im");
endmodule

bind correlation_to_stokes_extract cts_checker u_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.result_strobe (result_strobe),
	.result        (result)
);
